### design/pairwise_box_collision_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box collision table
// Each macro is a concurrent check in simulation and expands to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_BOX_COLLISION_TABLE_ASSERT_SVH
`define PAIRWISE_BOX_COLLISION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold in the same cycle as the condition.
`define PBCT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pbct: same-cycle check failed");
// The property must hold in the cycle after the condition.
`define PBCT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pbct: next-cycle check failed");
`else
`define PBCT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define PBCT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

### design/pbct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision table package
// Shared sizes, codes and the stored box record.
// ----------------------------------------------------------------------------
package pbct_pkg;

   localparam int NUM_SLOTS     = 8;
   localparam int NUM_KINDS     = 16;
   localparam int SLOT_W        = $clog2(NUM_SLOTS);
   localparam int SLOT_FIELD_W  = 3;
   localparam int KIND_W        = 4;
   localparam int COORD_W       = 16;
   localparam int SIZE_W        = 15;
   localparam int STATUS_W      = 3;
   localparam int NUM_MASK_REGS = 4;
   localparam int MASK_REG_W    = 64;
   localparam int MASK_BITS     = NUM_MASK_REGS * MASK_REG_W;
   localparam int CSR_INDEX_W   = $clog2(NUM_MASK_REGS);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SCAN   = 2'd2;

   localparam logic [STATUS_W-1:0] RSP_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_REMOVED = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_PAIR    = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_DONE    = 3'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] left_x;
      logic signed [COORD_W-1:0] top_y;
      logic [SIZE_W-1:0]         box_width;
      logic [SIZE_W-1:0]         box_height;
      logic [KIND_W-1:0]         kind;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   // Slot pair travelling down the scan pipeline.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [SLOT_W-1:0] lo;
      logic [SLOT_W-1:0] hi;
   } pair_tag_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

### design/pbct_box_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box store RAM
// Single write port, single read port, registered read with enable.
// ----------------------------------------------------------------------------
module pbct_box_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pbct_pair_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair check stage
// Looks up the kind-pair mask and tests two boxes for strict overlap,
// registering the verdict.
// ----------------------------------------------------------------------------
module pbct_pair_check (
   input  logic                             clock,
   input  logic                             en,
   input  logic                             both_occupied,
   input  pbct_pkg::box_type                box_a,
   input  pbct_pkg::box_type                box_b,
   input  logic [pbct_pkg::MASK_BITS-1:0]   pair_mask,
   output logic                             hit
);
   import pbct_pkg::*;

   logic signed [COORD_W:0] ax, ay, bx, by;
   logic signed [COORD_W:0] ax_end, ay_end, bx_end, by_end;
   logic                    kinds_ok, overlap;
   logic                    hit_ff;

   always_comb begin
      ax     = {box_a.left_x[COORD_W-1], box_a.left_x};
      ay     = {box_a.top_y[COORD_W-1], box_a.top_y};
      bx     = {box_b.left_x[COORD_W-1], box_b.left_x};
      by     = {box_b.top_y[COORD_W-1], box_b.top_y};
      ax_end = ax + $signed({2'b00, box_a.box_width});
      ay_end = ay + $signed({2'b00, box_a.box_height});
      bx_end = bx + $signed({2'b00, box_b.box_width});
      by_end = by + $signed({2'b00, box_b.box_height});
      overlap = (ax < bx_end) && (ax_end > bx) && (ay < by_end) && (ay_end > by);
      // The mask is laid out so that the first kind and second kind together
      // form the bit index.
      kinds_ok = ({1'b0, box_a.kind} < (KIND_W + 1)'(NUM_KINDS))
              && ({1'b0, box_b.kind} < (KIND_W + 1)'(NUM_KINDS))
              && pair_mask[{box_a.kind, box_b.kind}];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= both_occupied && kinds_ok && overlap;
      end
   end

   assign hit = hit_ff;

endmodule

### design/pairwise_box_collision_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision table
// Holds up to NUM_SLOTS boxes with kinds and reports overlapping pairs whose
// kind pair is enabled in the pair mask.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel is add (box fields and kind), remove
// (slot) or scan. Add and remove each give one rsp_ item with last set. A scan
// gives one rsp_ item per colliding pair, lower slot in slot_a, in ascending
// order, then a done item with last set. The unused opcode gives no result.
// Timing: an item is registered on acceptance and worked on the next cycle;
// an add or remove result is loaded from the exec state once the result
// register is free, and req_stall drops as it is loaded, so no new item is
// taken before the last one's result is loaded. A scan walks all slot pairs,
// NUM_SLOTS*(NUM_SLOTS-1)/2 of them, one per cycle while the result register
// is free, through a three-stage pipeline (issue and box RAM read, overlap and
// mask check, result); req_stall drops as its done item is loaded. Boxes live
// in a box RAM kept as two copies so that both boxes of a pair are read at once.
// Stalls: the result register frees on the cycle the receiver takes it; while
// rsp_stall holds a result, the scan pipeline freezes in place.
// Reset clears the occupancy flags, the pair mask and all handshakes; the box
// RAM needs no clearing as a slot that is not occupied never yields a hit.
// csr_write loads pair mask register csr_index; write it only while idle.
// ----------------------------------------------------------------------------
module pairwise_box_collision_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic signed [pbct_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [pbct_pkg::COORD_W-1:0] req_top_y,
   input  logic [pbct_pkg::SIZE_W-1:0]         req_box_width,
   input  logic [pbct_pkg::SIZE_W-1:0]         req_box_height,
   input  logic [pbct_pkg::KIND_W-1:0]         req_kind,
   input  logic [pbct_pkg::SLOT_FIELD_W-1:0]   req_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pbct_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pbct_pkg::SLOT_FIELD_W-1:0]   rsp_slot_a,
   output logic [pbct_pkg::SLOT_FIELD_W-1:0]   rsp_slot_b,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [pbct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbct_pkg::MASK_REG_W-1:0]     csr_wdata
);
   import pbct_pkg::*;

   state_type state_ff, state_in;

   logic [NUM_MASK_REGS-1:0][MASK_REG_W-1:0] pair_mask_ff;
   logic [MASK_BITS-1:0]                     mask_flat;

   logic [1:0]              op_ff;
   box_type                 box_ff;
   logic [SLOT_FIELD_W-1:0] rslot_ff;

   logic [NUM_SLOTS-1:0] occupied_ff, occupied_in;
   logic [SLOT_W-1:0]    free_slot;
   logic                 table_full;

   logic              issue_ff, issue_in;
   logic [SLOT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   pair_tag_type      s1_tag_ff, s1_tag_in, s2_tag_ff;
   logic              s1_occ_ff;
   logic              pair_hit;
   logic              adv;

   logic              ram_we;
   box_type           ram_a_data, ram_b_data;

   logic                    emit;
   logic [STATUS_W-1:0]     emit_status;
   logic [SLOT_FIELD_W-1:0] emit_slot_a, emit_slot_b;
   logic                    emit_last;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_a_ff, rsp_slot_b_ff;
   logic                    rsp_last_ff;

   assign mask_flat = pair_mask_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Lowest free slot; the last assignment in the loop wins.
   always_comb begin
      free_slot  = '0;
      table_full = 1'b1;
      for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
         if (!occupied_ff[j]) begin
            free_slot  = SLOT_W'(j);
            table_full = 1'b0;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      occupied_in = occupied_ff;
      issue_in    = issue_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      ram_we      = 1'b0;
      emit        = 1'b0;
      emit_status = RSP_DONE;
      emit_slot_a = '0;
      emit_slot_b = '0;
      emit_last   = 1'b1;
      s1_tag_in.valid = (state_ff == ST_SCAN) && issue_ff;
      s1_tag_in.last  = (lo_ff == SLOT_W'(NUM_SLOTS - 2))
                     && (hi_ff == SLOT_W'(NUM_SLOTS - 1));
      s1_tag_in.lo    = lo_ff;
      s1_tag_in.hi    = hi_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (adv) begin
               state_in = ST_IDLE;
               case (op_ff)
                  OP_ADD: begin
                     emit = 1'b1;
                     if (table_full) begin
                        emit_status = RSP_FULL;
                     end else begin
                        ram_we                 = 1'b1;
                        occupied_in[free_slot] = 1'b1;
                        emit_status            = RSP_ADDED;
                        emit_slot_a            = SLOT_FIELD_W'(free_slot);
                     end
                  end
                  OP_REMOVE: begin
                     emit        = 1'b1;
                     emit_status = RSP_REMOVED;
                     emit_slot_a = rslot_ff;
                     for (int j = 0; j < NUM_SLOTS; j++) begin
                        if (32'(rslot_ff) == j) begin
                           occupied_in[j] = 1'b0;
                        end
                     end
                  end
                  OP_SCAN: begin
                     state_in = ST_SCAN;
                     issue_in = 1'b1;
                     lo_in    = '0;
                     hi_in    = SLOT_W'(1);
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (adv) begin
               if (issue_ff) begin
                  if (s1_tag_in.last) begin
                     issue_in = 1'b0;
                  end else if (hi_ff == SLOT_W'(NUM_SLOTS - 1)) begin
                     lo_in = lo_ff + SLOT_W'(1);
                     hi_in = lo_ff + SLOT_W'(2);
                  end else begin
                     hi_in = hi_ff + SLOT_W'(1);
                  end
               end
               if (s2_tag_ff.valid) begin
                  if (pair_hit) begin
                     emit        = 1'b1;
                     emit_status = RSP_PAIR;
                     emit_slot_a = SLOT_FIELD_W'(s2_tag_ff.lo);
                     emit_slot_b = SLOT_FIELD_W'(s2_tag_ff.hi);
                     emit_last   = 1'b0;
                  end
                  if (s2_tag_ff.last) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (adv) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occupied_ff  <= '0;
         issue_ff     <= 1'b0;
         pair_mask_ff <= '0;
         s1_tag_ff    <= '0;
         s2_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         occupied_ff <= occupied_in;
         issue_ff    <= issue_in;
         if (csr_write) begin
            pair_mask_ff[csr_index] <= csr_wdata;
         end
         if (adv) begin
            s1_tag_ff <= s1_tag_in;
            s2_tag_ff <= s1_tag_ff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (adv) begin
         s1_occ_ff <= occupied_ff[lo_ff] && occupied_ff[hi_ff];
      end
      if ((state_ff == ST_IDLE) && req_valid) begin
         op_ff             <= req_opcode;
         box_ff.left_x     <= req_left_x;
         box_ff.top_y      <= req_top_y;
         box_ff.box_width  <= req_box_width;
         box_ff.box_height <= req_box_height;
         box_ff.kind       <= req_kind;
         rslot_ff          <= req_slot;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_slot_a_ff <= emit_slot_a;
         rsp_slot_b_ff <= emit_slot_b;
         rsp_last_ff   <= emit_last;
      end
   end

   // Two copies of the box store, written together, one read port each.
   pbct_box_ram #(
      .WIDTH (BOX_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_slot),
      .wr_data (box_ff),
      .rd_en   (adv),
      .rd_addr (lo_ff),
      .rd_data (ram_a_data)
   );

   pbct_box_ram #(
      .WIDTH (BOX_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_slot),
      .wr_data (box_ff),
      .rd_en   (adv),
      .rd_addr (hi_ff),
      .rd_data (ram_b_data)
   );

   pbct_pair_check u_pair_check (
      .clock         (clock),
      .en            (adv),
      .both_occupied (s1_occ_ff),
      .box_a         (ram_a_data),
      .box_b         (ram_b_data),
      .pair_mask     (mask_flat),
      .hit           (pair_hit)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot_a = rsp_slot_a_ff;
   assign rsp_slot_b = rsp_slot_b_ff;
   assign rsp_last   = rsp_last_ff;

`include "pairwise_box_collision_table_assert.svh"

   `PBCT_ASSERT_NEXT(a_occ_only_in_exec, clock, reset, state_ff != ST_EXEC, $stable(occupied_ff))
   `PBCT_ASSERT_IMPLIES(a_pipe_only_in_scan, clock, reset, s2_tag_ff.valid, state_ff == ST_SCAN)
   `PBCT_ASSERT_IMPLIES(a_pair_order, clock, reset, rsp_valid_ff && rsp_status_ff == RSP_PAIR, rsp_slot_a_ff < rsp_slot_b_ff && !rsp_last_ff)
   `PBCT_ASSERT_IMPLIES(a_done_is_last, clock, reset, rsp_valid_ff && rsp_status_ff == RSP_DONE, rsp_last_ff)

endmodule

### dv/collision_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision table checker
// Follows every accepted request, keeps its own copy of the slot table and
// the pair mask, and works out the responses that each request must give.
// Accepted responses are compared field by field, in order, with the oldest
// response still awaited.
// ----------------------------------------------------------------------------
module collision_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic signed [pbct_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [pbct_pkg::COORD_W-1:0] req_top_y,
   input  logic [pbct_pkg::SIZE_W-1:0]         req_box_width,
   input  logic [pbct_pkg::SIZE_W-1:0]         req_box_height,
   input  logic [pbct_pkg::KIND_W-1:0]         req_kind,
   input  logic [pbct_pkg::SLOT_FIELD_W-1:0]   req_slot,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pbct_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [pbct_pkg::SLOT_FIELD_W-1:0]   rsp_slot_a,
   input  logic [pbct_pkg::SLOT_FIELD_W-1:0]   rsp_slot_b,
   input  logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [pbct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbct_pkg::MASK_REG_W-1:0]     csr_wdata,
   output int                                  mismatch_total,
   output int                                  outstanding
);
   import pbct_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_FIELD_W-1:0] slot_a;
      logic [SLOT_FIELD_W-1:0] slot_b;
      logic                    last;
   } table_response_type;

   logic [MASK_REG_W-1:0] pair_masks [NUM_MASK_REGS];
   logic                  slot_used [NUM_SLOTS];
   box_type               slot_box [NUM_SLOTS];
   table_response_type    awaited_responses [$];
   int                    mismatches = 0;

   // Each mask register serves four first kinds, sixteen bits apiece.
   function automatic logic kinds_enabled(input logic [KIND_W-1:0] first,
                                          input logic [KIND_W-1:0] second);
      if (first >= NUM_KINDS || second >= NUM_KINDS) begin
         return 1'b0;
      end
      return pair_masks[first[3:2]][{first[1:0], second}];
   endfunction

   // Strict edges: boxes that only touch do not overlap.
   function automatic logic boxes_overlap(input box_type a, input box_type b);
      int ax, ay, aw, ah, bx, by, bw, bh;
      ax = $signed(a.left_x);
      ay = $signed(a.top_y);
      aw = a.box_width;
      ah = a.box_height;
      bx = $signed(b.left_x);
      by = $signed(b.top_y);
      bw = b.box_width;
      bh = b.box_height;
      return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
   endfunction

   task automatic await_response(input logic [STATUS_W-1:0] status,
                                 input logic [SLOT_FIELD_W-1:0] slot_a,
                                 input logic [SLOT_FIELD_W-1:0] slot_b,
                                 input logic last);
      awaited_responses.push_back('{status, slot_a, slot_b, last});
   endtask

   task automatic predict_table_item(input logic [1:0] opcode, input box_type box,
                                     input logic [SLOT_FIELD_W-1:0] slot);
      int free_slot;
      int i;
      int k;
      free_slot = -1;
      case (opcode)
         OP_ADD: begin
            for (i = NUM_SLOTS - 1; i >= 0; i--) begin
               if (!slot_used[i]) begin
                  free_slot = i;
               end
            end
            if (free_slot < 0) begin
               await_response(RSP_FULL, '0, '0, 1'b1);
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_box[free_slot]  = box;
               await_response(RSP_ADDED, SLOT_FIELD_W'(free_slot), '0, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (slot < NUM_SLOTS) begin
               slot_used[slot] = 1'b0;
            end
            await_response(RSP_REMOVED, slot, '0, 1'b1);
         end
         OP_SCAN: begin
            for (i = 0; i < NUM_SLOTS; i++) begin
               for (k = i + 1; k < NUM_SLOTS; k++) begin
                  if (slot_used[i] && slot_used[k] &&
                      kinds_enabled(slot_box[i].kind, slot_box[k].kind) &&
                      boxes_overlap(slot_box[i], slot_box[k])) begin
                     await_response(RSP_PAIR, SLOT_FIELD_W'(i), SLOT_FIELD_W'(k), 1'b0);
                  end
               end
            end
            await_response(RSP_DONE, '0, '0, 1'b1);
         end
         default: begin
            // The spare opcode leaves the table alone and gives nothing back.
         end
      endcase
   endtask

   function automatic int field_differs(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch_channels
      table_response_type want;
      box_type            box;
      int                 r;
      if (reset) begin
         for (r = 0; r < NUM_MASK_REGS; r++) begin
            pair_masks[r] = '0;
         end
         for (r = 0; r < NUM_SLOTS; r++) begin
            slot_used[r] = 1'b0;
         end
         awaited_responses.delete();
      end else begin
         if (csr_write) begin
            pair_masks[csr_index] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            box.left_x     = req_left_x;
            box.top_y      = req_top_y;
            box.box_width  = req_box_width;
            box.box_height = req_box_height;
            box.kind       = req_kind;
            predict_table_item(req_opcode, box, req_slot);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual status %0d slots %0d %0d last %0d",
                        $time, rsp_status, rsp_slot_a, rsp_slot_b, rsp_last);
               mismatches++;
            end else begin
               want = awaited_responses.pop_front();
               mismatches += field_differs("status", 4'(want.status), 4'(rsp_status));
               mismatches += field_differs("slot_a", 4'(want.slot_a), 4'(rsp_slot_a));
               mismatches += field_differs("slot_b", 4'(want.slot_b), 4'(rsp_slot_b));
               mismatches += field_differs("last", 4'(want.last), 4'(rsp_last));
            end
         end
      end
      mismatch_total <= mismatches;
      outstanding    <= awaited_responses.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision table testbench
// Drives add, remove, scan and spare-opcode items into the table under several
// pair mask settings, with random gaps on the request side and random stalls on
// the response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import pbct_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Extra pause, long enough for a whole scan of eight slots.
   localparam int SETTLE_CYCLES = 40;
   // The longest quiet stretch of a correct run is a scan with no pairs plus a
   // full stall and a full request gap.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 72;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_opcode = OP_ADD;
   logic signed [COORD_W-1:0]  req_left_x = '0;
   logic signed [COORD_W-1:0]  req_top_y = '0;
   logic [SIZE_W-1:0]          req_box_width = '0;
   logic [SIZE_W-1:0]          req_box_height = '0;
   logic [KIND_W-1:0]          req_kind = '0;
   logic [SLOT_FIELD_W-1:0]    req_slot = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [SLOT_FIELD_W-1:0]    rsp_slot_a;
   logic [SLOT_FIELD_W-1:0]    rsp_slot_b;
   logic                       rsp_last;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [MASK_REG_W-1:0]      csr_wdata = '0;
   int                         mismatch_total;
   int                         outstanding;
   logic                       calm = 1'b0;
   int                         stall_left = 0;
   int                         quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pairwise_box_collision_table DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_left_x     (req_left_x),
      .req_top_y      (req_top_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .req_kind       (req_kind),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_a     (rsp_slot_a),
      .rsp_slot_b     (rsp_slot_b),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   collision_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_left_x     (req_left_x),
      .req_top_y      (req_top_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .req_kind       (req_kind),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_a     (rsp_slot_a),
      .rsp_slot_b     (rsp_slot_b),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .outstanding    (outstanding)
   );

   // Response stalls come in bursts of random length, and none while calm is set.
   always @(posedge clock) begin
      if (reset || calm) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Called at a rising edge; returns at the edge where the item is taken with
   // valid still high, or after a random gap with valid low.
   task automatic send_item(input logic [1:0] opcode, input box_type box,
                            input logic [SLOT_FIELD_W-1:0] slot);
      req_valid      <= 1'b1;
      req_opcode     <= opcode;
      req_left_x     <= box.left_x;
      req_top_y      <= box.top_y;
      req_box_width  <= box.box_width;
      req_box_height <= box.box_height;
      req_kind       <= box.kind;
      req_slot       <= slot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic box_type make_box(input int x, input int y, input int w, input int h,
                                        input int kind);
      box_type box;
      box.left_x     = COORD_W'(x);
      box.top_y      = COORD_W'(y);
      box.box_width  = SIZE_W'(w);
      box.box_height = SIZE_W'(h);
      box.kind       = KIND_W'(kind);
      return box;
   endfunction

   // Mostly small boxes near the origin so that scans find many pairs.
   function automatic box_type random_box();
      box_type box;
      int      pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         box = make_box($urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick == 1) begin
         box = make_box($urandom_range(0, 1) ? -32768 : 32767,
                        $urandom_range(0, 1) ? -32768 : 32767,
                        $urandom_range(0, 1) ? 0 : 32767,
                        $urandom_range(0, 1) ? 0 : 32767, $urandom);
      end else begin
         box = make_box(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                        $urandom_range(0, 120), $urandom_range(0, 120),
                        $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
      end
      return box;
   endfunction

   task automatic send_add(input int x, input int y, input int w, input int h, input int kind);
      send_item(OP_ADD, make_box(x, y, w, h, kind), SLOT_FIELD_W'($urandom));
   endtask

   task automatic send_control(input logic [1:0] opcode, input int slot);
      send_item(opcode, random_box(), SLOT_FIELD_W'(slot));
   endtask

   task automatic send_random_items(input int count);
      int         n;
      int         pick;
      logic [1:0] opcode;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            opcode = OP_ADD;
         end else if (pick < 70) begin
            opcode = OP_REMOVE;
         end else if (pick < 97) begin
            opcode = OP_SCAN;
         end else begin
            opcode = OP_UNUSED;
         end
         send_item(opcode, random_box(), SLOT_FIELD_W'($urandom));
      end
   endtask

   // The spare opcode gives no response, so the block may still be busy when
   // the checker has nothing left to wait for; hence the extra pause.
   task automatic settle_table();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_pair_masks(input logic [MASK_REG_W-1:0] m0, input logic [MASK_REG_W-1:0] m1,
                                  input logic [MASK_REG_W-1:0] m2, input logic [MASK_REG_W-1:0] m3);
      logic [MASK_REG_W-1:0] values [NUM_MASK_REGS];
      int                    r;
      values = '{m0, m1, m2, m3};
      for (r = 0; r < NUM_MASK_REGS; r++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_W'(r);
         csr_wdata <= values[r];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   function automatic logic [MASK_REG_W-1:0] random_mask();
      return {$urandom, $urandom};
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_pair_masks('1, '1, '1, '1);
      send_control(OP_SCAN, 0);
      send_control(OP_REMOVE, 3);
      send_add(-32768, -32768, 32767, 32767, 15);
      send_add(32767, 32767, 0, 0, 0);
      send_add(0, 0, 10, 10, 1);
      // Shares only an edge with the previous box, so no pair.
      send_add(10, 0, 10, 10, 2);
      // A zero-size box strictly inside another one does collide.
      send_add(5, 5, 0, 0, 3);
      send_add(0, 10, 10, 10, 4);
      send_add(-5, -5, 30, 30, 14);
      // A zero-size box on a corner only touches.
      send_add(0, 0, 0, 0, 5);
      send_add(1, 1, 1, 1, 6);
      send_control(OP_SCAN, 0);
      send_control(OP_REMOVE, 4);
      send_control(OP_REMOVE, 4);
      send_add(1, 1, 1, 1, 15);
      send_control(OP_UNUSED, 7);
      send_control(OP_SCAN, 0);
      send_control(OP_REMOVE, 0);
      send_control(OP_REMOVE, 7);
      send_control(OP_REMOVE, 2);
      send_add(-1, -1, 3, 3, 8);
      send_control(OP_SCAN, 0);
      settle_table();

      load_pair_masks('0, '0, '0, '0);
      send_random_items(PHASE_ITEMS);
      settle_table();

      load_pair_masks(random_mask(), random_mask(), random_mask(), random_mask());
      send_random_items(PHASE_ITEMS);
      settle_table();

      // Only the low kinds pair among themselves, plus sparse random bits for kinds eight to eleven and two fixed bits.
      load_pair_masks(64'h000F_000F_000F_000F, '0, random_mask() & random_mask(),
                      64'h8000_0000_0000_0001);
      send_random_items(PHASE_ITEMS);
      settle_table();

      calm <= 1'b1;
      load_pair_masks('1, random_mask(), '1, random_mask());
      send_random_items(PHASE_ITEMS);
      settle_table();

      if (mismatch_total == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
